// ----- hdl/json_string_unescape_assert.svh -----
// ----------------------------------------------------------------------------
// json_string_unescape_assert.svh
// Assertion macros for the unescaper RTL.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property on every edge outside reset.
`define JSU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every edge, reset included.
`define JSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JSU_ASSERT(lbl, clk, rst_n, prop, msg)
`define JSU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hdl/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, constants and character helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int HexDigits  = 4;
  localparam int HexRadix   = 16;
  localparam int AsciiLimit = 128;
  localparam int SeqDepth   = 8;   // result slots per request, power of two
  localparam int SeqIdxW    = $clog2(SeqDepth);

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChLowU      = 8'h75;
  localparam logic [7:0] ChLowN      = 8'h6E;
  localparam logic [7:0] ChLowR      = 8'h72;
  localparam logic [7:0] ChLowT      = 8'h74;
  localparam logic [7:0] ChLowB      = 8'h62;
  localparam logic [7:0] ChLowF      = 8'h66;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;
  } jsu_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // take the input request and plan its results
    logic move;   // advance one planned result into the output register
  } jsu_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic plan_empty;  // the offered request produces no result
    logic seq_one;     // exactly one planned result remains
    logic out_free;    // output register can take a result this cycle
  } jsu_status_t;

  typedef enum logic [2:0] {
    PH_TEXT = 3'b001,
    PH_ESC  = 3'b010,
    PH_HEX  = 3'b100
  } phase_e;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } esc_map_t;

  // Digit value in the low four bits; HexRadix marks a non-hex byte.
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'(HexRadix);
    if (b >= 8'h30 && b <= 8'h39) r = 5'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) r = 5'(b - 8'h61 + 8'd10);
    else if (b >= 8'h41 && b <= 8'h46) r = 5'(b - 8'h41 + 8'd10);
    return r;
  endfunction

  // Single-character escapes other than backslash-u.
  function automatic esc_map_t esc_map(input logic [7:0] b);
    esc_map_t r;
    r.hit = 1'b1;
    case (b)
      ChQuote:     r.value = ChQuote;
      ChBackslash: r.value = ChBackslash;
      ChSlash:     r.value = ChSlash;
      ChLowN:      r.value = 8'h0A;
      ChLowR:      r.value = 8'h0D;
      ChLowT:      r.value = 8'h09;
      ChLowB:      r.value = 8'h08;
      ChLowF:      r.value = 8'h0C;
      default: begin
        r.hit   = 1'b0;
        r.value = b;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/jsu_ctrl.sv -----
// ----------------------------------------------------------------------------
// jsu_ctrl
// Controller: decides when to take a request and when to send a result.
// ----------------------------------------------------------------------------
module jsu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  jsu_pkg::jsu_status_t status_i,
  output jsu_pkg::jsu_cmd_t    cmd_o
);
  import jsu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        in_ready;

  always_comb begin
    cmd_o.move = (state_q == ST_SEND) && status_i.out_free;
    // Take the next request while the final planned result leaves.
    in_ready   = (state_q == ST_IDLE) || (cmd_o.move && status_i.seq_one);
    cmd_o.load = in_valid_i && in_ready;
    in_stall_o = !in_ready;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load && !status_i.plan_empty) state_d = ST_SEND;
      end
      ST_SEND: begin
        if (cmd_o.load) begin
          state_d = status_i.plan_empty ? ST_IDLE : ST_SEND;
        end else if (cmd_o.move && status_i.seq_one) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/jsu_datapath.sv -----
// ----------------------------------------------------------------------------
// jsu_datapath
// Escape decoding, hex digit buffer, result sequence and output register.
// ----------------------------------------------------------------------------
module jsu_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jsu_pkg::jsu_in_t     in_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output jsu_pkg::jsu_out_t    out_o,
  input  jsu_pkg::jsu_cmd_t    cmd_i,
  output jsu_pkg::jsu_status_t status_o
);
  import jsu_pkg::*;

  // Digit buffer and escape state.
  phase_e     phase_q, phase_d;
  logic [1:0] hex_cnt_q, hex_cnt_d;
  logic [7:0] hex_buf_q [HexDigits];
  logic [7:0] hex_buf_n [HexDigits];
  logic       hex_wr;

  // Planned results of the offered request.
  logic [7:0]         plan      [SeqDepth];
  logic [SeqIdxW-1:0] plan_n;
  logic               plan_mark;

  // Stored result sequence.
  logic [7:0]         seq_q     [SeqDepth];
  logic [SeqIdxW-1:0] seq_idx_q;
  logic [SeqIdxW-1:0] seq_len_q;
  logic               seq_mark_q;
  logic               seq_last_q;

  jsu_out_t out_q;
  logic     out_valid_q;

  logic [7:0] b;
  logic [4:0] b_val;
  logic [4:0] v0, v1, v2;
  logic [3:0] d0, d1, d2;
  logic [15:0] code;
  esc_map_t   esc;
  logic [2:0] fcnt;
  logic       do_flush;

  always_comb begin
    b     = in_i.in_byte;
    b_val = hex_val(b);
    v0    = hex_val(hex_buf_q[0]);
    v1    = hex_val(hex_buf_q[1]);
    v2    = hex_val(hex_buf_q[2]);
    d0    = v0[3:0];
    d1    = v1[3:0];
    d2    = v2[3:0];
    code  = {d0, d1, d2, b_val[3:0]};
    esc   = esc_map(b);
  end

  // Plan every result the request causes, up to a full escape replay.
  always_comb begin
    phase_d   = phase_q;
    hex_cnt_d = hex_cnt_q;
    hex_wr    = 1'b0;
    plan_n    = '0;
    fcnt      = '0;
    do_flush  = 1'b0;
    plan_mark = 1'b0;
    for (int i = 0; i < SeqDepth; i++) plan[i] = '0;
    for (int i = 0; i < HexDigits; i++) hex_buf_n[i] = hex_buf_q[i];

    case (phase_q)
      PH_ESC: begin
        phase_d = PH_TEXT;
        if (b == ChLowU) begin
          phase_d   = PH_HEX;
          hex_cnt_d = '0;
        end else if (esc.hit) begin
          plan[plan_n] = esc.value;
          plan_n       = plan_n + 1'b1;
        end else begin
          plan[plan_n]        = ChBackslash;
          plan[plan_n + 1'b1] = b;
          plan_n              = plan_n + 2'd2;
        end
      end
      PH_HEX: begin
        if (b_val < 5'(HexRadix)) begin
          hex_wr               = 1'b1;
          hex_buf_n[hex_cnt_q] = b;
          if (hex_cnt_q == 2'(HexDigits - 1)) begin
            phase_d   = PH_TEXT;
            hex_cnt_d = '0;
            if (code < 16'(AsciiLimit)) begin
              plan[plan_n] = code[7:0];
              plan_n       = plan_n + 1'b1;
            end else begin
              // Give the six-character escape back unchanged.
              do_flush = 1'b1;
              fcnt     = 3'(HexDigits);
            end
          end else begin
            hex_cnt_d = hex_cnt_q + 1'b1;
          end
        end else begin
          do_flush  = 1'b1;
          fcnt      = {1'b0, hex_cnt_q};
          hex_cnt_d = '0;
          phase_d   = PH_TEXT;
        end
      end
      default: begin
        phase_d = PH_TEXT;
      end
    endcase

    if (do_flush) begin
      plan[plan_n]        = ChBackslash;
      plan[plan_n + 1'b1] = ChLowU;
      for (int i = 0; i < HexDigits; i++) begin
        if (3'(i) < fcnt) plan[plan_n + 3'(i) + 3'd2] = hex_buf_n[i];
      end
      plan_n = plan_n + 3'd2 + fcnt;
    end

    // Replay the offending byte, or take plain text, as ordinary input.
    if ((phase_q == PH_HEX && b_val >= 5'(HexRadix)) ||
        (phase_q != PH_ESC && phase_q != PH_HEX)) begin
      if (b == ChBackslash) begin
        phase_d = PH_ESC;
      end else begin
        plan[plan_n] = b;
        plan_n       = plan_n + 1'b1;
      end
    end

    if (in_i.in_last) begin
      if (phase_d == PH_HEX) begin
        plan[plan_n]        = ChBackslash;
        plan[plan_n + 1'b1] = ChLowU;
        for (int i = 0; i < HexDigits; i++) begin
          if (2'(i) < hex_cnt_d && i < HexDigits - 1) begin
            plan[plan_n + 3'(i) + 3'd2] = hex_buf_n[i];
          end
        end
        plan_n = plan_n + 3'd2 + {1'b0, hex_cnt_d};
      end
      // Drop a trailing lone backslash.
      phase_d   = PH_TEXT;
      hex_cnt_d = '0;
      plan_mark = (plan_n == '0);
    end
  end

  always_comb begin
    status_o.plan_empty = (plan_n == '0) && !in_i.in_last;
    status_o.seq_one    = (seq_idx_q + 1'b1 == seq_len_q);
    status_o.out_free   = !out_valid_q || !out_stall_i;
    out_valid_o         = out_valid_q;
    out_o               = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TEXT;
      hex_cnt_q   <= '0;
      seq_idx_q   <= '0;
      seq_len_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        phase_q   <= phase_d;
        hex_cnt_q <= hex_cnt_d;
        seq_idx_q <= '0;
        seq_len_q <= plan_mark ? SeqIdxW'(1) : plan_n;
      end else if (cmd_i.move) begin
        seq_idx_q <= seq_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.move) begin
      out_q.out_byte <= seq_mark_q ? 8'h00 : seq_q[seq_idx_q];
      out_q.has_byte <= !seq_mark_q;
      out_q.out_last <= seq_last_q && status_o.seq_one;
    end
    if (cmd_i.load) begin
      for (int i = 0; i < SeqDepth; i++) seq_q[i] <= plan[i];
      seq_mark_q <= plan_mark;
      seq_last_q <= in_i.in_last;
      if (hex_wr) hex_buf_q[hex_cnt_q] <= b;
    end
  end

endmodule

// ----- hdl/json_string_unescape.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape
// JSON string body unescaper, one raw byte per request.
// ----------------------------------------------------------------------------
// Input channel in_valid_i / in_stall_o carries one raw byte of the escaped
// string body and a flag for its final byte. Output channel out_valid_o /
// out_stall_i carries unescaped bytes; has_byte low marks a bare end marker,
// and out_last flags the final result of each string.
// A request is planned into a result sequence (at most six entries) in the
// cycle it is accepted and stored; results then leave one per cycle through
// the output register while the receiver does not stall. Requests giving
// zero or one result stream at one per cycle while the output does not
// stall; a request giving more results holds the input while the single
// result sequencer sends them. The next request is taken in the cycle the
// final result of the current one moves to the output.
// Reset clears the escape state, the sequence index and length, and the output valid.
// While the receiver stalls, the output register holds its result and the
// sequence waits, which in turn stalls the input.
// ----------------------------------------------------------------------------
module json_string_unescape (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  jsu_pkg::jsu_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output jsu_pkg::jsu_out_t out_o
);
  import jsu_pkg::*;

  jsu_cmd_t    cmd;
  jsu_status_t status;

  jsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  jsu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

`include "json_string_unescape_assert.svh"

  `JSU_ASSERT_ALWAYS(a_marker_last, clk_i, (out_valid_o && !out_o.has_byte) |-> out_o.out_last, "bare end marker without last flag")
  `JSU_ASSERT(a_marker_zero, clk_i, rst_ni, (out_valid_o && !out_o.has_byte) |-> (out_o.out_byte == 8'h00), "bare end marker carries a byte")
  `JSU_ASSERT(a_load_overlap, clk_i, rst_ni, (cmd.load && cmd.move) |-> status.seq_one, "request taken before sequence drained")
  `JSU_ASSERT(a_move_sets_valid, clk_i, rst_ni, cmd.move |=> out_valid_o, "moved result not presented")

endmodule
